@@ rtl/pdet_pkg.sv @@
// Shared types and constants for the pen digitizer event tracker.
// No dependencies; used by every module of the block but the queue.
`default_nettype none

package pdet_pkg;

	// Default depth of the report queue between front and back
	localparam int unsigned QueueDepthDefault = 4;

	// Pen status codes
	localparam logic [7:0] StOut       = 8'h00;
	localparam logic [7:0] StHover     = 8'h10;
	localparam logic [7:0] StPad       = 8'h11;
	localparam logic [7:0] StBDown     = 8'h12;
	localparam logic [7:0] StTDown     = 8'h13;
	localparam logic [7:0] StPrevReset = 8'hff;

	// Register reset values
	localparam logic [15:0] ViewWidthReset  = 16'd1023;
	localparam logic [15:0] ViewHeightReset = 16'd599;

	// Sensor ranges and reciprocals for the constant divides
	localparam logic [15:0] XRange = 16'h37ff;
	localparam logic [15:0] YRange = 16'h1fff;
	localparam int          XShift = 45;
	localparam int          YShift = 44;
	localparam logic [31:0] XRecip = 32'((64'd1 << XShift) / 64'(XRange));
	localparam logic [31:0] YRecip = 32'((64'd1 << YShift) / 64'(YRange));

	// Register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		RegViewWidth  = 2'd0,
		RegViewHeight = 2'd1,
		RegWakeEnable = 2'd2,
		RegHostAsleep = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		EvPosition = 3'd0,
		EvRelease  = 3'd1,
		EvWakeup   = 3'd2,
		EvBDown    = 3'd3,
		EvBUp      = 3'd4,
		EvTDown    = 3'd5,
		EvTUp      = 3'd6
	} event_kind_t;

	// One classified report as it sits in the queue
	typedef struct packed {
		event_kind_t [3:0] kinds;
		logic [2:0]        count;
		logic [15:0]       raw_x;
		logic [15:0]       raw_y;
		logic [13:0]       pressure;
	} entry_t;

	// Report data carried alongside the scaler stages
	typedef struct packed {
		event_kind_t [3:0] kinds;
		logic [2:0]        count;
		logic [13:0]       pressure;
	} meta_t;

	typedef struct packed {
		logic wake_enable;
		logic host_asleep;
	} front_cfg_t;

	typedef struct packed {
		logic [15:0] view_width;
		logic [15:0] view_height;
	} scale_cfg_t;

endpackage

`default_nettype wire

@@ rtl/pdet_queue.sv @@
// Small first-in first-out queue of classified reports between front and back.
// Generic width and depth; no package dependency.
`default_nettype none

module pdet_queue #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [Width-1:0]      pop_data,
	output logic                  empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

@@ rtl/pdet_front.sv @@
// Front end: accepts reports, drops unused ones, tracks pen status and
// button latches, and queues the event list. Depends on pdet_pkg.
`default_nettype none

module pdet_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [55:0]           s_axis_tdata,  // pen_status, raw_x, raw_y, raw_pressure
	input  wire logic [7:0]            s_axis_tuser,  // report_mode
	input  wire pdet_pkg::front_cfg_t  cfg,
	output logic                       push,
	output pdet_pkg::entry_t           entry,
	input  wire logic                  full
);

	logic [7:0] prev_status_q;
	logic       touch_q;
	logic       b_latch_q;
	logic       t_latch_q;

	logic [7:0] status;
	logic       used;
	logic       xfer;
	logic       touch_d;
	logic       b_latch_d;
	logic       t_latch_d;
	logic [2:0] count;
	pdet_pkg::event_kind_t [3:0] kinds;

	assign status        = s_axis_tdata[7:0];
	assign used          = |s_axis_tuser[7:1];
	assign s_axis_tready = !full;
	assign xfer          = s_axis_tvalid && s_axis_tready && used;
	assign push          = xfer && (count != 3'd0);

	assign entry.kinds    = kinds;
	assign entry.count    = count;
	assign entry.raw_x    = s_axis_tdata[23:8];
	assign entry.raw_y    = s_axis_tdata[39:24];
	assign entry.pressure = s_axis_tdata[55:42];

	// Per-status rules: event list in order and next latch state
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			kinds[i] = pdet_pkg::EvPosition;
		end
		count     = 3'd0;
		touch_d   = touch_q;
		b_latch_d = b_latch_q;
		t_latch_d = t_latch_q;
		case (status)
			pdet_pkg::StOut: begin
				if (touch_q) begin
					kinds[count[1:0]] = pdet_pkg::EvRelease;
					count = count + 3'd1;
					touch_d = 1'b0;
					if (cfg.wake_enable && cfg.host_asleep) begin
						kinds[count[1:0]] = pdet_pkg::EvWakeup;
						count = count + 3'd1;
					end
				end
				if (b_latch_q) begin
					b_latch_d = 1'b0;
					kinds[count[1:0]] = pdet_pkg::EvBUp;
					count = count + 3'd1;
				end
				if (t_latch_q) begin
					t_latch_d = 1'b0;
					kinds[count[1:0]] = pdet_pkg::EvTUp;
					count = count + 3'd1;
				end
			end
			pdet_pkg::StHover: begin
				if (prev_status_q == pdet_pkg::StBDown && b_latch_q) begin
					kinds[count[1:0]] = pdet_pkg::EvBDown;
					count = count + 3'd1;
				end
				if (prev_status_q == pdet_pkg::StTDown && t_latch_q) begin
					kinds[count[1:0]] = pdet_pkg::EvTDown;
					count = count + 3'd1;
				end
				if (b_latch_q || t_latch_q) begin
					kinds[count[1:0]] = pdet_pkg::EvPosition;
					count = count + 3'd1;
					touch_d = 1'b1;
				end else if (touch_q) begin
					kinds[count[1:0]] = pdet_pkg::EvRelease;
					count = count + 3'd1;
					touch_d = 1'b0;
					if (cfg.wake_enable && cfg.host_asleep) begin
						kinds[count[1:0]] = pdet_pkg::EvWakeup;
						count = count + 3'd1;
					end
				end
			end
			pdet_pkg::StPad: begin
				kinds[count[1:0]] = pdet_pkg::EvPosition;
				count = count + 3'd1;
				touch_d = 1'b1;
				if (b_latch_q) begin
					b_latch_d = 1'b0;
					kinds[count[1:0]] = pdet_pkg::EvBUp;
					count = count + 3'd1;
				end
				if (t_latch_q) begin
					t_latch_d = 1'b0;
					kinds[count[1:0]] = pdet_pkg::EvTUp;
					count = count + 3'd1;
				end
			end
			pdet_pkg::StBDown: begin
				if (prev_status_q == pdet_pkg::StHover) begin
					if (!b_latch_q) begin
						b_latch_d = 1'b1;
					end else begin
						b_latch_d = 1'b0;
						kinds[count[1:0]] = pdet_pkg::EvBUp;
						count = count + 3'd1;
					end
				end
				if (t_latch_q) begin
					if (prev_status_q == pdet_pkg::StHover) begin
						t_latch_d = 1'b0;
						kinds[count[1:0]] = pdet_pkg::EvTUp;
						count = count + 3'd1;
					end else if (prev_status_q == pdet_pkg::StTDown) begin
						kinds[count[1:0]] = pdet_pkg::EvTDown;
						count = count + 3'd1;
					end else begin
						kinds[count[1:0]] = pdet_pkg::EvPosition;
						count = count + 3'd1;
						touch_d = 1'b1;
					end
				end
			end
			pdet_pkg::StTDown: begin
				if (prev_status_q == pdet_pkg::StHover) begin
					if (!t_latch_q) begin
						t_latch_d = 1'b1;
					end else begin
						t_latch_d = 1'b0;
						kinds[count[1:0]] = pdet_pkg::EvTUp;
						count = count + 3'd1;
					end
				end
			end
			default: begin
				// unknown status: no events, only remembered
			end
		endcase
	end

	// Tracker state, updated on every used report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_status_q <= pdet_pkg::StPrevReset;
			touch_q       <= 1'b0;
			b_latch_q     <= 1'b0;
			t_latch_q     <= 1'b0;
		end else if (xfer) begin
			prev_status_q <= status;
			touch_q       <= touch_d;
			b_latch_q     <= b_latch_d;
			t_latch_q     <= t_latch_d;
		end
	end

	a_pad_sets_touch: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && status == pdet_pkg::StPad) |=> (touch_q && !b_latch_q && !t_latch_q))
		else $error("on-pad report did not leave touch set and buttons clear");

endmodule

`default_nettype wire

@@ rtl/pdet_back.sv @@
// Back end: scales the coordinates of queued reports in a three-stage
// pipeline and sends their events one per transfer. Depends on pdet_pkg.
`default_nettype none

module pdet_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pdet_pkg::scale_cfg_t  cfg,
	input  wire logic                  q_empty,
	input  wire pdet_pkg::entry_t      q_data,
	output logic                       q_pop,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [47:0]                m_axis_tdata,  // view_x, view_y, pressure_out, 2 zero bits
	output logic [2:0]                 m_axis_tuser,  // event_kind
	output logic                       m_axis_tlast   // last_event
);

	// Scaler pipeline
	logic              valid_s1, valid_s2, valid_s3;
	pdet_pkg::meta_t   meta_s1, meta_s2, meta_s3;
	logic [31:0]       px_s1, py_s1, px_s2, py_s2;
	logic [19:0]       q0x_s2, q0y_s2, q0x_s3, q0y_s3;
	logic [15:0]       remx_s3, remy_s3;

	// Event sender
	logic                        em_valid_q;
	pdet_pkg::event_kind_t [3:0] em_kinds_q;
	logic [2:0]                  em_cnt_q;
	logic [1:0]                  em_idx_q;
	logic [15:0]                 em_x_q, em_y_q;
	logic [13:0]                 em_p_q;

	logic                  adv;
	logic                  em_load;
	logic                  em_last;
	logic [63:0]           prodx, prody;
	logic [35:0]           diffx, diffy;
	logic [20:0]           qx, qy;
	logic [15:0]           satx, saty;
	pdet_pkg::event_kind_t kind_sel;
	logic                  is_pos;

	assign em_last = ({1'b0, em_idx_q} == (em_cnt_q - 3'd1));
	assign em_load = valid_s3 && (!em_valid_q || (m_axis_tready && em_last));
	assign adv     = !valid_s3 || em_load;
	assign q_pop   = adv && !q_empty;

	// Reciprocal products and remainders
	assign prodx = 64'(px_s1) * 64'(pdet_pkg::XRecip);
	assign prody = 64'(py_s1) * 64'(pdet_pkg::YRecip);
	assign diffx = {4'b0, px_s2} - (36'(q0x_s2) * 36'(pdet_pkg::XRange));
	assign diffy = {4'b0, py_s2} - (36'(q0y_s2) * 36'(pdet_pkg::YRange));

	// Quotient correction and saturation
	assign qx   = {1'b0, q0x_s3} + 21'(remx_s3 >= pdet_pkg::XRange);
	assign qy   = {1'b0, q0y_s3} + 21'(remy_s3 >= pdet_pkg::YRange);
	assign satx = (|qx[20:16]) ? 16'hffff : qx[15:0];
	assign saty = (|qy[20:16]) ? 16'hffff : qy[15:0];

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !q_empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage payload; the x quotient fits in 19 bits
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.kinds    <= q_data.kinds;
			meta_s1.count    <= q_data.count;
			meta_s1.pressure <= q_data.pressure;
			px_s1            <= 32'(q_data.raw_x) * 32'(cfg.view_width);
			py_s1            <= 32'(q_data.raw_y) * 32'(cfg.view_height);
			meta_s2          <= meta_s1;
			px_s2            <= px_s1;
			py_s2            <= py_s1;
			q0x_s2           <= {1'b0, prodx[pdet_pkg::XShift +: 19]};
			q0y_s2           <= prody[pdet_pkg::YShift +: 20];
			meta_s3          <= meta_s2;
			q0x_s3           <= q0x_s2;
			q0y_s3           <= q0y_s2;
			remx_s3          <= diffx[15:0];
			remy_s3          <= diffy[15:0];
		end
	end

	// Sender control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_idx_q   <= 2'd0;
		end else if (em_load) begin
			em_valid_q <= 1'b1;
			em_idx_q   <= 2'd0;
		end else if (em_valid_q && m_axis_tready) begin
			if (em_last) begin
				em_valid_q <= 1'b0;
			end else begin
				em_idx_q <= em_idx_q + 2'd1;
			end
		end
	end

	// Sender payload
	always_ff @(posedge clk) begin
		if (em_load) begin
			em_kinds_q <= meta_s3.kinds;
			em_cnt_q   <= meta_s3.count;
			em_p_q     <= meta_s3.pressure;
			em_x_q     <= satx;
			em_y_q     <= saty;
		end
	end

	// Output fields; coordinates and pressure only on position events
	assign kind_sel      = em_kinds_q[em_idx_q];
	assign is_pos        = (kind_sel == pdet_pkg::EvPosition);
	assign m_axis_tvalid = em_valid_q;
	assign m_axis_tuser  = kind_sel;
	assign m_axis_tlast  = em_last;
	assign m_axis_tdata  = {2'b00,
		(is_pos ? em_p_q : 14'd0),
		(is_pos ? em_y_q : 16'd0),
		(is_pos ? em_x_q : 16'd0)};

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q |-> ({1'b0, em_idx_q} < em_cnt_q))
		else $error("event index beyond event count");

	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (meta_s3.count != 3'd0 && meta_s3.count <= 3'd4))
		else $error("scaled report carries no or too many events");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(em_valid_q && !m_axis_tready) |=> (em_valid_q && $stable(em_idx_q)))
		else $error("event sender moved while stalled");

endmodule

`default_nettype wire

@@ rtl/pen_digitizer_event_tracker_unit.sv @@
// Path: an accepted report goes through the queue, the scaler stages and the
// sender register; further events of the same report follow one per cycle while
// the output is ready. Throughput: one report per cycle while each gives one
// event and output is ready; a report with n events takes n sender transfers.
// Reset: asynchronous, registers to their reset values, tracker state cleared.
// Top level: config registers, front, queue and back. Depends on pdet_pkg.
`default_nettype none

module pen_digitizer_event_tracker_unit #(
	parameter int unsigned QueueDepth = pdet_pkg::QueueDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// report input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // pen_status, raw_x, raw_y, raw_pressure
	input  wire logic [7:0]  s_axis_tuser,  // report_mode
	// event output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // view_x, view_y, pressure_out, 2 zero bits
	output logic [2:0]       m_axis_tuser,  // event_kind
	output logic             m_axis_tlast   // last_event
);

	logic [15:0] view_width_q;
	logic [15:0] view_height_q;
	logic        wake_enable_q;
	logic        host_asleep_q;

	logic                  cfg_wr;
	pdet_pkg::reg_index_t  reg_idx;
	pdet_pkg::front_cfg_t  front_cfg;
	pdet_pkg::scale_cfg_t  scale_cfg;
	pdet_pkg::entry_t      push_entry;
	pdet_pkg::entry_t      pop_entry;
	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  empty;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = pdet_pkg::reg_index_t'(paddr[3:2]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q  <= pdet_pkg::ViewWidthReset;
			view_height_q <= pdet_pkg::ViewHeightReset;
			wake_enable_q <= 1'b0;
			host_asleep_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				pdet_pkg::RegViewWidth:  view_width_q  <= pwdata[15:0];
				pdet_pkg::RegViewHeight: view_height_q <= pwdata[15:0];
				pdet_pkg::RegWakeEnable: wake_enable_q <= pwdata[0];
				pdet_pkg::RegHostAsleep: host_asleep_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (reg_idx)
			pdet_pkg::RegViewWidth:  prdata = {16'd0, view_width_q};
			pdet_pkg::RegViewHeight: prdata = {16'd0, view_height_q};
			pdet_pkg::RegWakeEnable: prdata = {31'd0, wake_enable_q};
			pdet_pkg::RegHostAsleep: prdata = {31'd0, host_asleep_q};
			default:                 prdata = 32'd0;
		endcase
	end

	assign front_cfg.wake_enable = wake_enable_q;
	assign front_cfg.host_asleep = host_asleep_q;
	assign scale_cfg.view_width  = view_width_q;
	assign scale_cfg.view_height = view_height_q;

	pdet_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (front_cfg),
		.push          (push),
		.entry         (push_entry),
		.full          (full)
	);

	pdet_queue #(
		.Width ($bits(pdet_pkg::entry_t)),
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_entry),
		.empty     (empty)
	);

	pdet_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (scale_cfg),
		.q_empty       (empty),
		.q_data        (pop_entry),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
